FILE: rtl/rcc_pkg.sv
// ---------------------------------------------------------------------------
// rcc_pkg
// Shared types, constants and lookup tables for the reference cell
// classifier (frame geometry, time reference table, gain phase tables).
// ---------------------------------------------------------------------------
package rcc_pkg;

  localparam logic signed [7:0] LOWEST_CARRIER    = -8'sd106;
  localparam logic signed [7:0] HIGHEST_CARRIER   = 8'sd106;
  localparam logic signed [7:0] AFS_EDGE          = 8'sd106;
  localparam logic signed [7:0] BOOST_OUTER       = 8'sd106;
  localparam logic signed [7:0] BOOST_INNER       = 8'sd102;
  localparam logic [5:0]        SYMBOLS_PER_FRAME = 6'd40;
  localparam logic [5:0]        SYM_AFS_FIRST     = 6'd4;
  localparam logic [5:0]        SYM_AFS_LAST      = 6'd39;
  localparam logic [5:0]        SYM_FAC_FIRST     = 6'd5;
  localparam logic [5:0]        SYM_FAC_LAST      = 6'd26;
  localparam logic [5:0]        SYM_FAC_ODD       = 6'd7;
  localparam logic [5:0]        SYM_SDC_END       = 6'd5;
  localparam logic [3:0]        M_MAX             = 4'd9;
  localparam logic [3:0]        FAC_LAST_COUNT    = 4'd3;
  localparam logic signed [7:0] FAC_ODD_ADD       = -8'sd96;
  localparam logic signed [7:0] FAC_ODD_DROP      = -8'sd86;

  // per symbol class: first fac carrier and carrier count
  localparam logic signed [8:0] FAC_FIRST [4] = '{-9'sd78, -9'sd90, -9'sd86, -9'sd82};
  localparam logic [3:0]        FAC_COUNT [4] = '{4'd11, 4'd12, 4'd12, 4'd11};

  localparam logic [9:0] GAIN_R [4][10] = '{
    '{10'd39,  10'd118, 10'd197, 10'd276, 10'd354, 10'd433, 10'd39,  10'd118, 10'd197, 10'd276},
    '{10'd37,  10'd183, 10'd402, 10'd37,  10'd183, 10'd402, 10'd37,  10'd183, 10'd402, 10'd47},
    '{10'd110, 10'd329, 10'd475, 10'd110, 10'd329, 10'd475, 10'd110, 10'd329, 10'd475, 10'd110},
    '{10'd79,  10'd158, 10'd236, 10'd315, 10'd394, 10'd473, 10'd79,  10'd158, 10'd236, 10'd315}
  };
  localparam logic [9:0] GAIN_Z [4][10] = '{
    '{10'd473, 10'd394, 10'd315, 10'd236, 10'd158, 10'd79,  10'd0,   10'd0,   10'd0,   10'd0},
    '{10'd183, 10'd914, 10'd402, 10'd37,  10'd475, 10'd841, 10'd768, 10'd768, 10'd987, 10'd183},
    '{10'd549, 10'd622, 10'd475, 10'd110, 10'd37,  10'd622, 10'd256, 10'd768, 10'd329, 10'd549},
    '{10'd79,  10'd158, 10'd236, 10'd315, 10'd394, 10'd473, 10'd158, 10'd315, 10'd473, 10'd630}
  };
  localparam logic [9:0] GAIN_Q [4][10] = '{
    '{10'd329, 10'd489,  10'd894, 10'd419, 10'd607, 10'd519, 10'd1020, 10'd942, 10'd817,  10'd939},
    '{10'd824, 10'd1023, 10'd74,  10'd319, 10'd225, 10'd207, 10'd348,  10'd422, 10'd395,  10'd92},
    '{10'd959, 10'd379,  10'd7,   10'd738, 10'd500, 10'd920, 10'd440,  10'd727, 10'd263,  10'd733},
    '{10'd907, 10'd946,  10'd924, 10'd91,  10'd189, 10'd133, 10'd910,  10'd804, 10'd1022, 10'd433}
  };

  typedef struct packed {
    logic       hit;
    logic [9:0] phase;
  } time_ref_t;

  // classification flags carried down the pipeline
  typedef struct packed {
    logic time_pilot;
    logic gain_pilot;
    logic boosted;
    logic afs_cell;
    logic fac_cell;
    logic sdc_cell;
  } cell_flags_t;

  // first stage result handed to the phase datapath
  typedef struct packed {
    cell_flags_t       flags;
    logic [9:0]        time_phase;
    logic signed [4:0] p;
    logic [9:0]        r;
    logic [9:0]        z;
    logic [9:0]        q;
  } cell_stage_t;

  function automatic time_ref_t time_lookup(input logic signed [7:0] c);
    time_ref_t t;
    t.hit = 1'b1;
    case (c)
      -8'sd80: t.phase = 10'd219;
      -8'sd79: t.phase = 10'd475;
      -8'sd77: t.phase = 10'd989;
      -8'sd53: t.phase = 10'd652;
      -8'sd52: t.phase = 10'd652;
      -8'sd51: t.phase = 10'd140;
      -8'sd32: t.phase = 10'd819;
      -8'sd31: t.phase = 10'd819;
      8'sd12:  t.phase = 10'd907;
      8'sd13:  t.phase = 10'd907;
      8'sd14:  t.phase = 10'd651;
      8'sd21:  t.phase = 10'd903;
      8'sd22:  t.phase = 10'd391;
      8'sd23:  t.phase = 10'd903;
      8'sd40:  t.phase = 10'd203;
      8'sd41:  t.phase = 10'd203;
      8'sd42:  t.phase = 10'd203;
      8'sd67:  t.phase = 10'd797;
      8'sd68:  t.phase = 10'd29;
      8'sd79:  t.phase = 10'd508;
      8'sd80:  t.phase = 10'd508;
      default: begin
        t.hit   = 1'b0;
        t.phase = 10'd0;
      end
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/ofdm_reference_cell_classifier_top.sv
// ---------------------------------------------------------------------------
// ofdm_reference_cell_classifier_top
// Classifies one cell position (symbol, carrier) per beat into time, gain,
// afs, fac and sdc flags with time and gain reference phases.
// ---------------------------------------------------------------------------
// an accepted input beat passes the decode, stage 2 and stage 3 registers on its way to m_tvalid
// throughput: one cell per cycle; a three-stage valid pipeline that holds
//   under m_tready backpressure without losing or repeating beats
// the gain phase multiplies (p*p, p*z, then p*p*r) set the stage split
// reset: synchronous rst clears all stage valid bits; data regs not reset
module ofdm_reference_cell_classifier_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // symbol[5:0], carrier[13:6], zero[15:14]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // time_pilot[0], time_phase[10:1], gain_pilot[11],
                                // gain_phase[21:12], boosted[22], afs_cell[23],
                                // fac_cell[24], sdc_cell[25], zero[31:26]
);

  logic                 dec_valid;
  logic                 dec_ready;
  rcc_pkg::cell_stage_t dec_cell;
  rcc_pkg::cell_flags_t flags;
  logic [9:0]           time_phase;
  logic [9:0]           gain_phase;

  rcc_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .symbol    (s_tdata[5:0]),
    .carrier   (signed'(s_tdata[13:6])),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_cell  (dec_cell)
  );

  rcc_phase u_phase (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (dec_valid),
    .in_ready       (dec_ready),
    .in_cell        (dec_cell),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_flags      (flags),
    .out_time_phase (time_phase),
    .out_gain_phase (gain_phase)
  );

  assign m_tdata = {6'd0, flags.sdc_cell, flags.fac_cell, flags.afs_cell, flags.boosted,
                    gain_phase, flags.gain_pilot, time_phase, flags.time_pilot};

`ifndef SYNTH
  // boost only ever marks gain cells
  a_boost_gain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[22] |-> m_tdata[11])
    else $error("boosted beat without gain pilot");

  // sdc cells exclude gain cells
  a_sdc_gain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[25] && m_tdata[11]))
    else $error("sdc and gain pilot both set");

  // afs and fac live in disjoint symbols
  a_afs_fac: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[23] && m_tdata[24]))
    else $error("afs and fac both set");

  // phases are cleared when their pilot flag is off
  a_phase_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] || (m_tdata[10:1] == 10'd0)) &&
                 (m_tdata[11] || (m_tdata[21:12] == 10'd0)))
    else $error("phase set without pilot");

  // the pipeline never stalls the input while the output is being drained
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled with output ready");
`endif

endmodule

FILE: rtl/rcc_decode.sv
// ---------------------------------------------------------------------------
// rcc_decode
// First pipeline stage: band and frame checks, time reference lookup, gain,
// afs, fac and sdc decisions, gain table fetch and carrier offset p.
// ---------------------------------------------------------------------------
module rcc_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [5:0]          symbol,
  input  logic signed [7:0]   carrier,
  output logic                out_valid,
  input  logic                out_ready,
  output rcc_pkg::cell_stage_t out_cell
);

  logic                 valid;
  rcc_pkg::cell_stage_t stage;
  rcc_pkg::cell_stage_t stage_next;
  rcc_pkg::time_ref_t   tref;
  logic                 in_band;
  logic                 in_frame;
  logic [1:0]           n;
  logic [3:0]           m;
  logic signed [8:0]    d;
  logic                 gain;
  logic                 afs;
  logic                 fac;
  logic [1:0]           fac_cls;
  logic [3:0]           fac_cnt;
  logic signed [8:0]    fac_d;

  assign in_ready = !valid || out_ready;

  always_comb begin
    in_band  = (carrier >= rcc_pkg::LOWEST_CARRIER) && (carrier <= rcc_pkg::HIGHEST_CARRIER);
    in_frame = symbol < rcc_pkg::SYMBOLS_PER_FRAME;
    tref     = rcc_pkg::time_lookup(carrier);
    n        = symbol[1:0];
    m        = (symbol[5:2] > rcc_pkg::M_MAX) ? rcc_pkg::M_MAX : symbol[5:2];
    d        = 9'(signed'({carrier[7], carrier}) - 9'sd2 - signed'({5'd0, n, 2'b00}));
    // |d| mod 16 == 0 exactly when the low nibble of d is zero
    gain     = (d[3:0] == 4'd0);

    afs = (carrier >= -rcc_pkg::AFS_EDGE) && (carrier <= rcc_pkg::AFS_EDGE) &&
          (carrier[1:0] == 2'b10) &&
          ((symbol == rcc_pkg::SYM_AFS_FIRST) || (symbol == rcc_pkg::SYM_AFS_LAST));

    fac_cls = 2'(symbol - rcc_pkg::SYM_FAC_FIRST);
    fac_cnt = (symbol == rcc_pkg::SYM_FAC_LAST) ? rcc_pkg::FAC_LAST_COUNT
                                                : rcc_pkg::FAC_COUNT[fac_cls];
    fac_d   = 9'(signed'({carrier[7], carrier}) - rcc_pkg::FAC_FIRST[fac_cls]);
    if ((symbol < rcc_pkg::SYM_FAC_FIRST) || (symbol > rcc_pkg::SYM_FAC_LAST)) begin
      fac = 1'b0;
    end else if ((symbol == rcc_pkg::SYM_FAC_ODD) && (carrier == rcc_pkg::FAC_ODD_ADD)) begin
      fac = 1'b1;
    end else if ((symbol == rcc_pkg::SYM_FAC_ODD) && (carrier == rcc_pkg::FAC_ODD_DROP)) begin
      fac = 1'b0;
    end else begin
      fac = !fac_d[8] && (fac_d[3:0] == 4'd0) && ({1'b0, fac_d[7:4]} < {1'b0, fac_cnt});
    end

    stage_next.flags.time_pilot = in_band && tref.hit;
    stage_next.time_phase       = (in_band && tref.hit) ? tref.phase : 10'd0;
    stage_next.flags.gain_pilot = in_band && in_frame && gain;
    stage_next.flags.boosted    = in_band && in_frame && gain &&
                                  ((carrier == -rcc_pkg::BOOST_OUTER) ||
                                   (carrier == -rcc_pkg::BOOST_INNER) ||
                                   (carrier == rcc_pkg::BOOST_INNER) ||
                                   (carrier == rcc_pkg::BOOST_OUTER));
    stage_next.flags.afs_cell   = in_band && in_frame && afs;
    stage_next.flags.fac_cell   = in_band && in_frame && fac;
    stage_next.flags.sdc_cell   = in_band && in_frame && (symbol < rcc_pkg::SYM_SDC_END) &&
                                  !gain && !((symbol == 6'd0) && tref.hit) &&
                                  !((symbol == rcc_pkg::SYM_AFS_FIRST) && afs);
    // d is a multiple of 16 when p is used, so the shift is exact
    stage_next.p = d[8:4];
    stage_next.r = rcc_pkg::GAIN_R[n][m];
    stage_next.z = rcc_pkg::GAIN_Z[n][m];
    stage_next.q = rcc_pkg::GAIN_Q[n][m];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= stage_next;
    end
  end

  assign out_valid = valid;
  assign out_cell  = stage;

endmodule

FILE: rtl/rcc_phase.sv
// ---------------------------------------------------------------------------
// rcc_phase
// Second and third pipeline stages: gain phase p*p*R + p*Z + Q mod 1024,
// then the output register with the packed result beat.
// ---------------------------------------------------------------------------
module rcc_phase (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rcc_pkg::cell_stage_t in_cell,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rcc_pkg::cell_flags_t out_flags,
  output logic [9:0]           out_time_phase,
  output logic [9:0]           out_gain_phase
);

  // stage 2 registers
  logic                 valid2;
  rcc_pkg::cell_flags_t flags2;
  logic [9:0]           time_phase2;
  logic [7:0]           pp2;
  logic [9:0]           pz2;
  logic [9:0]           r2;
  logic [9:0]           q2;
  // stage 3 registers
  logic                 valid3;
  rcc_pkg::cell_flags_t flags3;
  logic [9:0]           time_phase3;
  logic [9:0]           gain_phase3;

  logic                 ready3;
  logic                 ready2;
  logic signed [9:0]    pp_full;
  logic signed [15:0]   pz_full;
  logic [17:0]          ppr_full;
  logic [9:0]           phase_next;

  assign ready3   = !valid3 || out_ready;
  assign ready2   = !valid2 || ready3;
  assign in_ready = ready2;

  always_comb begin
    pp_full    = in_cell.p * in_cell.p;
    pz_full    = in_cell.p * signed'({1'b0, in_cell.z});
    ppr_full   = pp2 * r2;
    // everything wraps mod 1024, so only the low bits are kept
    phase_next = 10'(ppr_full[9:0] + pz2 + q2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      if (ready2) begin
        valid2 <= in_valid;
      end
      if (ready3) begin
        valid3 <= valid2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && in_valid) begin
      flags2      <= in_cell.flags;
      time_phase2 <= in_cell.time_phase;
      pp2         <= pp_full[7:0];
      pz2         <= pz_full[9:0];
      r2          <= in_cell.r;
      q2          <= in_cell.q;
    end
    if (ready3 && valid2) begin
      flags3      <= flags2;
      time_phase3 <= time_phase2;
      gain_phase3 <= flags2.gain_pilot ? phase_next : 10'd0;
    end
  end

  assign out_valid      = valid3;
  assign out_flags      = flags3;
  assign out_time_phase = time_phase3;
  assign out_gain_phase = gain_phase3;

endmodule
